### rtl/core/ptd_pkg.sv
// Package: shared types and codes for the periodic task dispatcher.
`timescale 1ns / 1ps

package ptd_pkg;

  localparam int TICK_W    = 64;
  localparam int PERIOD_W  = 32;
  localparam int DIV_RADIX = 4;                      // quotient bits per cycle
  localparam int DIV_STEPS = TICK_W / DIV_RADIX;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic CMD_REGISTER = 1'b0;
  localparam logic CMD_TICK     = 1'b1;

  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_DUE     = 1'b1;

  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_NO_DESC = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_READ,
    ST_LOAD,
    ST_DIV,
    ST_CHECK,
    ST_FLUSH
  } ptd_state_t;

endpackage

### rtl/core/periodic_task_dispatcher.sv
// Top level: slot table in memory, tick counter, scan sequencer and serial modulo unit.
`timescale 1ns / 1ps

//  channel | handshake            | payload
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_stall  | command, slot, period, has_task, descriptor_valid
//  out     | out_valid / out_stall| kind, due_slot, status, last
//
//  Register command: accepted, then its status leaves through the output register
//  as soon as that register is free. Tick: accepted, then each slot is read in
//  ST_READ; a used slot also passes ST_LOAD, and one with a task and a nonzero period
//  then passes ST_DIV and ST_CHECK; the modulo unit retires 4 quotient bits a cycle.
//  One item is in work at a time.
//  rst is synchronous; it clears the occupied marks, the tick count and all control.
//  A stalled output holds the scan at the next due slot; no result is dropped.

module periodic_task_dispatcher
  import ptd_pkg::*;
#(
  parameter int SLOTS = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                command,
  input  logic [3:0]          slot,
  input  logic [PERIOD_W-1:0] period,
  input  logic                has_task,
  input  logic                descriptor_valid,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                kind,
  output logic [3:0]          due_slot,
  output logic                status,
  output logic                last
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  ptd_state_t state, state_next;

  // table: {has_task, period}; occupied marks kept in flops
  logic [PERIOD_W:0]   tbl_mem [SLOTS];
  logic [PERIOD_W:0]   rd_data;
  logic [SLOTS-1:0]    used;

  logic [TICK_W-1:0]   tick_total;
  logic [IDX_W-1:0]    idx;
  logic                last_idx;

  // latched register request
  logic [3:0]          req_slot;
  logic [PERIOD_W-1:0] req_period;
  logic                req_has_task;
  logic                req_dv;
  logic [IDX_W+3:0]    req_slot_ext;
  logic [IDX_W-1:0]    wr_idx;
  logic                req_in_range;
  logic                mem_we;

  // modulo unit
  logic [TICK_W-1:0]    div_num;
  logic [PERIOD_W-1:0]  div_per;
  logic [PERIOD_W-1:0]  rem;
  logic [PERIOD_W-1:0]  rem_next;
  logic [DIV_CNT_W-1:0] div_cnt;

  logic                pend_valid;
  logic [3:0]          pend_slot;
  logic [IDX_W+3:0]    idx_ext;
  logic [3:0]          due_cnt;

  logic                out_free;
  logic                out_load;
  logic                kind_next;
  logic [3:0]          due_slot_next;
  logic                status_next;
  logic                last_next;
  logic                due;
  logic                hold_check;
  logic                rd_active;
  logic                advance;

  assign req_slot_ext = (IDX_W + 4)'(req_slot);
  assign wr_idx       = req_slot_ext[IDX_W-1:0];
  assign req_in_range = req_slot_ext < (IDX_W + 4)'(SLOTS);
  assign idx_ext      = (IDX_W + 4)'(idx);
  assign last_idx     = idx == IDX_W'(SLOTS - 1);

  assign out_free   = !out_valid || !out_stall;
  assign due        = rem == '0;
  assign hold_check = due && pend_valid && !out_free;
  assign rd_active  = rd_data[PERIOD_W] && (rd_data[PERIOD_W-1:0] != '0);

  // restoring division, DIV_RADIX bits per cycle; remainder stays below the period
  always_comb begin
    logic [PERIOD_W:0] r;
    rem_next = rem;
    for (int k = 0; k < DIV_RADIX; k++) begin
      r = {rem_next, div_num[TICK_W-1-k]};
      if (r >= {1'b0, div_per}) begin
        r = r - {1'b0, div_per};
      end
      rem_next = r[PERIOD_W-1:0];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && !in_stall) begin
          state_next = (command == CMD_REGISTER) ? ST_REG : ST_READ;
        end
      end
      ST_REG: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (used[idx]) begin
          state_next = ST_LOAD;
        end else begin
          state_next = last_idx ? ST_FLUSH : ST_READ;
        end
      end
      ST_LOAD: begin
        if (rd_active) begin
          state_next = ST_DIV;
        end else begin
          state_next = last_idx ? ST_FLUSH : ST_READ;
        end
      end
      ST_DIV: begin
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = ST_CHECK;
        end
      end
      ST_CHECK: begin
        // the scan ends after the sixteenth due slot of a tick
        if (!hold_check) begin
          state_next = (last_idx || (due && due_cnt == 4'd15)) ? ST_FLUSH : ST_READ;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid || out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall      = rst || (state != ST_IDLE);
    out_load      = 1'b0;
    mem_we        = 1'b0;
    kind_next     = KIND_DUE;
    due_slot_next = pend_slot;
    status_next   = STATUS_OK;
    last_next     = 1'b0;
    unique case (state)
      ST_REG: begin
        out_load      = out_free;
        mem_we        = out_free && req_dv && req_in_range && !used[wr_idx];
        kind_next     = KIND_STATUS;
        due_slot_next = '0;
        status_next   = req_dv ? STATUS_OK : STATUS_NO_DESC;
        last_next     = 1'b1;
      end
      ST_CHECK: begin
        // a new due slot releases the one held back, which is then not last
        out_load = due && pend_valid && out_free;
      end
      ST_FLUSH: begin
        out_load  = pend_valid && out_free;
        last_next = 1'b1;
      end
      default: ;
    endcase
  end

  assign advance = (state == ST_READ || state == ST_LOAD || state == ST_CHECK)
                   && state_next == ST_READ;

  // table memory; writes happen only while idle of scans, so no forwarding
  always_ff @(posedge clk) begin
    if (mem_we) begin
      tbl_mem[wr_idx] <= {req_has_task, req_period};
    end
    rd_data <= tbl_mem[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      used       <= '0;
      tick_total <= '0;
      idx        <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
      div_cnt    <= '0;
      due_cnt    <= '0;
    end else begin
      state <= state_next;

      if (state == ST_IDLE && in_valid && !in_stall) begin
        idx     <= '0;
        due_cnt <= '0;
        if (command == CMD_TICK) begin
          tick_total <= tick_total + TICK_W'(1);
        end
      end else if (advance) begin
        idx <= idx + IDX_W'(1);
      end

      if (mem_we) begin
        used[wr_idx] <= 1'b1;
      end

      if (state == ST_LOAD) begin
        div_cnt <= '0;
      end else if (state == ST_DIV) begin
        div_cnt <= div_cnt + DIV_CNT_W'(1);
      end

      if (state == ST_CHECK && due && !hold_check) begin
        pend_valid <= 1'b1;
        due_cnt    <= due_cnt + 4'd1;
      end else if (state == ST_FLUSH && out_load) begin
        pend_valid <= 1'b0;
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid && !in_stall) begin
      req_slot     <= slot;
      req_period   <= period;
      req_has_task <= has_task;
      req_dv       <= descriptor_valid;
    end

    if (state == ST_LOAD) begin
      rem     <= '0;
      div_num <= tick_total;
      div_per <= rd_data[PERIOD_W-1:0];
    end else if (state == ST_DIV) begin
      rem     <= rem_next;
      div_num <= {div_num[TICK_W-DIV_RADIX-1:0], DIV_RADIX'(0)};
    end

    if (state == ST_CHECK && due && !hold_check) begin
      pend_slot <= idx_ext[3:0];
    end

    if (out_load) begin
      kind     <= kind_next;
      due_slot <= due_slot_next;
      status   <= status_next;
      last     <= last_next;
    end
  end

endmodule

### rtl/core/ptd_checker.sv
// Port checker for the periodic task dispatcher, bound to the top level.
`timescale 1ns / 1ps

module ptd_checker
  import ptd_pkg::*;
(
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_stall,
  input logic                command,
  input logic [3:0]          slot,
  input logic [PERIOD_W-1:0] period,
  input logic                has_task,
  input logic                descriptor_valid,
  input logic                out_valid,
  input logic                out_stall,
  input logic                kind,
  input logic [3:0]          due_slot,
  input logic                status,
  input logic                last
);

  // a stalled transfer holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(due_slot)
                               && $stable(status) && $stable(last))
    else $error("output payload changed under stall");

  // a registration status is a single, final result
  a_status_single: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_STATUS |-> last && due_slot == 4'd0)
    else $error("registration status not single");

  a_due_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == KIND_DUE |-> status == STATUS_OK)
    else $error("due result carries error status");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // no input is taken while reset is asserted
  a_no_accept_rst: assert property (@(posedge clk)
    rst |-> in_stall)
    else $error("input accepted during reset");

endmodule

bind periodic_task_dispatcher ptd_checker u_ptd_checker (.*);
